[hw/rtl/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and fixed widths of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    // rate registers and block counters
    localparam int RATE_W  = 18;
    localparam int CNT32_W = 32;

    // serial arithmetic unit
    localparam int ACC_W   = 64;              // accumulator and dividend shift register
    localparam int RQ_W    = 52;              // output-count quotient (dividend < 2^52)
    localparam int DREM_W  = RATE_W + 1;      // partial remainder, divisor up to 2*rate
    localparam int STEP_W  = 7;

    localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(RATE_W);
    localparam logic [STEP_W-1:0] RDIV_STEPS = STEP_W'(RQ_W);
    localparam logic [STEP_W-1:0] BDIV_STEPS = STEP_W'(ACC_W);
    localparam logic [STEP_W-1:0] ADIV_STEPS = STEP_W'(DREM_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_RATE  = 1'b0,
        CFG_OUT_RATE = 1'b1
    } lir_cfg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_RMUL,
        ST_RDIV,
        ST_DECIDE,
        ST_POP,
        ST_BMUL,
        ST_BDIV,
        ST_ADIV,
        ST_EMIT
    } lir_state_t;

endpackage

[hw/rtl/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Mono sample rate converter by linear interpolation, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// The block takes one input sample at a time and answers with zero to
// MAX_UPSAMPLE+1 output samples; the run ends with the input that carries
// tlast, and the last output of the run carries tlast. All arithmetic runs
// through one shift-add multiplier (one multiplier bit per cycle) and one
// restoring divider (one quotient bit per cycle). With equal or zero rates a
// sample passes straight through. Otherwise each input first sizes the run
// (18 multiply steps, 52 quotient bits), then computes each interpolated
// output (18 multiply steps, 64 quotient bits for the rounded blend, 19
// quotient bits for the phase step). Outputs are also released from the
// two-deep hold, and the block waits while the output register is full and
// m_axis_tready stays low. A new input is taken once the previous one has
// finished; the output register may still hold its last result. Rates are
// to be written through the cfg port only while the block is idle; the block
// itself does not enforce it.
module linear_interp_resampler #(
    parameter int MAX_UPSAMPLE = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lir_pkg::RATE_W-1:0]          cfg_data,
    // input samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample_in, zero pad above
    input  logic                                s_axis_tlast,   // final_in
    // output samples
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // sample_out, zero pad above
    output logic                                m_axis_tlast    // final_out
);
    import lir_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CAP     = MAX_UPSAMPLE + 1;
    localparam int N_W     = $clog2(CAP + 1);
    localparam logic [N_W-1:0] CAP_N = N_W'(CAP);

    // control state
    lir_state_t                state_reg, state_next;
    logic [RATE_W-1:0]         in_rate_reg, in_rate_next;
    logic [RATE_W-1:0]         out_rate_reg, out_rate_next;
    logic                      fin_reg, fin_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [CNT32_W-1:0]        seen_reg, seen_next;
    logic [CNT32_W-1:0]        sent_reg, sent_next;
    logic [RATE_W-1:0]         phase_reg, phase_next;
    logic [CNT32_W-1:0]        src_reg, src_next;
    logic [1:0]                hold_cnt_reg, hold_cnt_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;

    // payload and datapath
    logic signed [SAMPLE_BITS-1:0] c_reg, c_next;
    logic [SAMPLE_BITS-1:0]    hold0_reg, hold0_next;
    logic [SAMPLE_BITS-1:0]    hold1_reg, hold1_next;
    logic [SAMPLE_BITS-1:0]    blend_reg, blend_next;
    logic [RQ_W-1:0]           r_reg, r_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [ACC_W-1:0]          mca_reg, mca_next;
    logic [ACC_W-1:0]          mcb_reg, mcb_next;
    logic [RATE_W-1:0]         mpa_reg, mpa_next;
    logic [RATE_W-1:0]         mpb_reg, mpb_next;
    logic [ACC_W-1:0]          dq_reg, dq_next;
    logic [DREM_W-1:0]         drem_reg, drem_next;
    logic [DREM_W-1:0]         dsor_reg, dsor_next;
    logic [SAMPLE_BITS-1:0]    m_data_reg, m_data_next;
    logic                      m_last_reg, m_last_next;

    // decision terms
    logic                      pass_mode;
    logic                      out_free;
    logic                      last_step;
    logic                      room;
    logic [CNT32_W:0]          m_cur;
    logic [CNT32_W:0]          sent1;
    logic [CNT32_W:0]          src1;
    logic [CNT32_W:0]          src2;
    logic                      pop_ok;
    logic                      calc_ok;
    logic                      last_flag;

    // serial unit terms
    logic [ACC_W-1:0]          mul_acc_step;
    logic [DREM_W:0]           div_trial;
    logic                      div_ge;
    logic [DREM_W-1:0]         div_rem_step;
    logic [ACC_W-1:0]          div_q_step;
    logic [ACC_W-1:0]          rdiv_dividend;
    logic [ACC_W-1:0]          bdiv_dividend;
    logic [DREM_W-1:0]         adiv_sum;
    logic [RQ_W-1:0]           r_q;
    logic signed [SAMPLE_BITS-1:0] s0_sel;
    logic signed [SAMPLE_BITS-1:0] s1_sel;
    logic signed [SAMPLE_BITS:0]   s_diff;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_data_reg);
    assign m_axis_tlast  = m_last_reg;

    // configuration writes
    always_comb
    begin
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IN_RATE:  in_rate_next  = cfg_data;
                CFG_OUT_RATE: out_rate_next = cfg_data;
            endcase
        end
    end

    // decision terms shared by both sequencer blocks
    always_comb
    begin
        pass_mode = (in_rate_reg == '0) || (out_rate_reg == '0)
                    || (in_rate_reg == out_rate_reg);
        out_free  = !m_valid_reg || m_axis_tready;
        last_step = (cnt_reg == STEP_W'(1));
        room      = (n_reg < CAP_N);
        m_cur     = {1'b0, seen_reg} + (CNT32_W+1)'(1);
        sent1     = {1'b0, sent_reg} + (CNT32_W+1)'(1);
        src1      = {1'b0, src_reg} + (CNT32_W+1)'(1);
        src2      = {1'b0, src_reg} + (CNT32_W+1)'(2);
        if (fin_reg)
        begin
            pop_ok  = (hold_cnt_reg != 2'd0) && room && (RQ_W'(sent_reg) < r_reg);
            calc_ok = (hold_cnt_reg == 2'd0) && room && (RQ_W'(sent_reg) < r_reg);
        end
        else
        begin
            pop_ok  = (hold_cnt_reg != 2'd0) && room && (RQ_W'(sent1) < r_reg);
            calc_ok = (hold_cnt_reg != 2'd2) && room && (src2 <= m_cur);
        end
        // no further output follows once the cap or the run length is reached
        last_flag = fin_reg && (((n_reg + 1'b1) == CAP_N) || (RQ_W'(sent1) >= r_reg));
    end

    // serial multiply and divide steps
    always_comb
    begin
        mul_acc_step = acc_reg + (mpa_reg[0] ? mca_reg : '0) + (mpb_reg[0] ? mcb_reg : '0);
        div_trial    = {drem_reg, dq_reg[ACC_W-1]};
        div_ge       = (div_trial >= {1'b0, dsor_reg});
        div_rem_step = div_ge ? DREM_W'(div_trial - {1'b0, dsor_reg}) : DREM_W'(div_trial);
        div_q_step   = {dq_reg[ACC_W-2:0], div_ge};
        // (2*m*b + a), left aligned for a 52-bit quotient
        rdiv_dividend = ((acc_reg << 1) + ACC_W'(in_rate_reg)) << (ACC_W - RQ_W);
        // 2*(num + half*b) + b, modulo 2^64
        bdiv_dividend = ((acc_reg + (ACC_W'(out_rate_reg) << (SAMPLE_BITS - 1))) << 1)
                        + ACC_W'(out_rate_reg);
        adiv_sum      = {1'b0, phase_reg} + {1'b0, in_rate_reg};
        r_q           = div_q_step[RQ_W-1:0];
        // blend operands: samples at source index and index+1
        s0_sel = (src1 >= m_cur) ? c_reg : prev_reg;
        s1_sel = (src2 >= m_cur) ? c_reg : prev_reg;
        s_diff = (SAMPLE_BITS+1)'(s1_sel) - (SAMPLE_BITS+1)'(s0_sel);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = pass_mode ? ST_PASS : ST_RMUL;
            ST_PASS:
                if (out_free)
                    state_next = ST_IDLE;
            ST_RMUL:
                if (last_step)
                    state_next = ST_RDIV;
            ST_RDIV:
                if (last_step)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (pop_ok)
                    state_next = ST_POP;
                else if (calc_ok)
                    state_next = ST_BMUL;
                else
                    state_next = ST_IDLE;
            ST_POP:
                if (out_free)
                    state_next = ST_DECIDE;
            ST_BMUL:
                if (last_step)
                    state_next = ST_BDIV;
            ST_BDIV:
                if (last_step)
                    state_next = ST_ADIV;
            ST_ADIV:
                if (last_step)
                    state_next = fin_reg ? ST_EMIT : ST_DECIDE;
            ST_EMIT:
                if (out_free)
                    state_next = ST_DECIDE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fin_next      = fin_reg;
        prev_next     = prev_reg;
        seen_next     = seen_reg;
        sent_next     = sent_reg;
        phase_next    = phase_reg;
        src_next      = src_reg;
        hold_cnt_next = hold_cnt_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        c_next        = c_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        blend_next    = blend_reg;
        r_next        = r_reg;
        acc_next      = acc_reg;
        mca_next      = mca_reg;
        mcb_next      = mcb_reg;
        mpa_next      = mpa_reg;
        mpb_next      = mpb_reg;
        dq_next       = dq_reg;
        drem_next     = drem_reg;
        dsor_next     = dsor_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_axis_tready ? 1'b0 : m_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    c_next   = s_axis_tdata[SAMPLE_BITS-1:0];
                    fin_next = s_axis_tlast;
                    n_next   = '0;
                    // m * out_rate for the run length
                    acc_next = '0;
                    mca_next = ACC_W'(m_cur);
                    mpa_next = out_rate_reg;
                    mcb_next = '0;
                    mpb_next = '0;
                    cnt_next = MUL_STEPS;
                end
            end

            ST_PASS:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = c_reg;
                    m_last_next  = fin_reg;
                    if (fin_reg)
                    begin
                        prev_next     = '0;
                        seen_next     = '0;
                        sent_next     = '0;
                        phase_next    = '0;
                        src_next      = '0;
                        hold_cnt_next = '0;
                    end
                    else
                    begin
                        prev_next = c_reg;
                        seen_next = seen_reg + CNT32_W'(1);
                    end
                end
            end

            ST_RMUL, ST_BMUL:
            begin
                acc_next = mul_acc_step;
                mca_next = mca_reg << 1;
                mcb_next = mcb_reg << 1;
                mpa_next = mpa_reg >> 1;
                mpb_next = mpb_reg >> 1;
                cnt_next = cnt_reg - STEP_W'(1);
            end

            ST_RDIV:
            begin
                if (cnt_reg == '0)
                begin
                    dq_next   = rdiv_dividend;
                    drem_next = '0;
                    dsor_next = {in_rate_reg, 1'b0};
                    cnt_next  = RDIV_STEPS;
                end
                else
                begin
                    dq_next   = div_q_step;
                    drem_next = div_rem_step;
                    cnt_next  = cnt_reg - STEP_W'(1);
                    if (last_step)
                        r_next = (fin_reg && (r_q == '0)) ? RQ_W'(1) : r_q;
                end
            end

            ST_DECIDE:
            begin
                if (pop_ok)
                begin
                    // handled in ST_POP
                end
                else if (calc_ok)
                begin
                    // s0*b + (s1-s0)*rem
                    acc_next = '0;
                    mca_next = ACC_W'(s0_sel);
                    mpa_next = out_rate_reg;
                    mcb_next = ACC_W'(s_diff);
                    mpb_next = phase_reg;
                    cnt_next = MUL_STEPS;
                end
                else if (fin_reg)
                begin
                    prev_next     = '0;
                    seen_next     = '0;
                    sent_next     = '0;
                    phase_next    = '0;
                    src_next      = '0;
                    hold_cnt_next = '0;
                end
                else
                begin
                    prev_next = c_reg;
                    seen_next = m_cur[CNT32_W-1:0];
                end
            end

            ST_POP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = hold0_reg;
                    m_last_next   = last_flag;
                    hold0_next    = hold1_reg;
                    hold_cnt_next = hold_cnt_reg - 2'd1;
                    sent_next     = sent_reg + CNT32_W'(1);
                    n_next        = n_reg + 1'b1;
                end
            end

            ST_BDIV:
            begin
                if (cnt_reg == '0)
                begin
                    dq_next   = bdiv_dividend;
                    drem_next = '0;
                    dsor_next = {out_rate_reg, 1'b0};
                    cnt_next  = BDIV_STEPS;
                end
                else if (last_step)
                begin
                    // quotient minus half is a flip of the top bit
                    blend_next = {~div_q_step[SAMPLE_BITS-1], div_q_step[SAMPLE_BITS-2:0]};
                    // phase step: (rem + a) / b
                    dq_next    = {adiv_sum, {(ACC_W - DREM_W){1'b0}}};
                    drem_next  = '0;
                    dsor_next  = {1'b0, out_rate_reg};
                    cnt_next   = ADIV_STEPS;
                end
                else
                begin
                    dq_next   = div_q_step;
                    drem_next = div_rem_step;
                    cnt_next  = cnt_reg - STEP_W'(1);
                end
            end

            ST_ADIV:
            begin
                dq_next   = div_q_step;
                drem_next = div_rem_step;
                cnt_next  = cnt_reg - STEP_W'(1);
                if (last_step)
                begin
                    src_next   = src_reg + CNT32_W'(div_q_step[DREM_W-1:0]);
                    phase_next = div_rem_step[RATE_W-1:0];
                    if (!fin_reg)
                    begin
                        if (hold_cnt_reg == 2'd0)
                            hold0_next = blend_reg;
                        else
                            hold1_next = blend_reg;
                        hold_cnt_next = hold_cnt_reg + 2'd1;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = blend_reg;
                    m_last_next  = last_flag;
                    sent_next    = sent_reg + CNT32_W'(1);
                    n_next       = n_reg + 1'b1;
                end
            end

            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_rate_reg  <= RATE_W'(44100);
            out_rate_reg <= RATE_W'(44100);
            fin_reg      <= 1'b0;
            prev_reg     <= '0;
            seen_reg     <= '0;
            sent_reg     <= '0;
            phase_reg    <= '0;
            src_reg      <= '0;
            hold_cnt_reg <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
            fin_reg      <= fin_next;
            prev_reg     <= prev_next;
            seen_reg     <= seen_next;
            sent_reg     <= sent_next;
            phase_reg    <= phase_next;
            src_reg      <= src_next;
            hold_cnt_reg <= hold_cnt_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload and serial unit registers
    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        hold0_reg  <= hold0_next;
        hold1_reg  <= hold1_next;
        blend_reg  <= blend_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        mca_reg    <= mca_next;
        mcb_reg    <= mcb_next;
        mpa_reg    <= mpa_next;
        mpb_reg    <= mpb_next;
        dq_reg     <= dq_next;
        drem_reg   <= drem_next;
        dsor_reg   <= dsor_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

[hw/rtl/lir_checker.sv]
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks of the resampler, attached by bind.
// ----------------------------------------------------------------------------
module lir_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                             m_axis_tlast
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // one input at a time: an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    // results are only produced while an input is being worked on
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output request raised while idle");

endmodule

bind linear_interp_resampler lir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lir_checker (.*);

[tb/linear_interp_resampler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_tb
// Self-checking bench for the linear interpolation resampler.
// ----------------------------------------------------------------------------
// Samples go in as blocks of requests closed by tlast. A scoreboard class
// keeps its own copy of the rates and the interpolation state, works out the
// outputs that each accepted input releases, and checks every output request
// in order. A short directed part covers pass-through, full 8x upsampling,
// a ratio beyond the burst cap, extreme downsampling and a rate change in the
// middle of a block. Random blocks follow under several rate settings and
// three idling patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module linear_interp_resampler_tb;

    import lir_pkg::*;

    localparam int SAMPLE_W        = 16;
    localparam int MAX_UP          = 8;
    localparam int BURST_CAP       = MAX_UP + 1;
    localparam int SETTLE_CYCLES   = 1500;   // longest quiet input, with margin
    localparam int HOLD_OFF_CYCLES = 4000;
    localparam int MAX_REPORTS     = 10;

    // one output request: sample and end-of-block flag
    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                fin;
    } resampled_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the interpolation state and the outputs still owed
    // ------------------------------------------------------------------------
    class resample_scoreboard;
        logic [RATE_W-1:0]          in_rate;
        logic [RATE_W-1:0]          out_rate;
        logic signed [SAMPLE_W-1:0] prev_smp;
        logic signed [SAMPLE_W-1:0] held [2];
        int                         held_cnt;
        logic [31:0]                n_in;
        logic [31:0]                n_out;
        logic [31:0]                src_idx;
        logic [RATE_W-1:0]          phase_rem;
        int                         burst;
        resampled_t                 due_q [$];
        int                         n_checked;
        int                         n_bad;

        function new();
            in_rate   = 18'd44100;
            out_rate  = 18'd44100;
            n_checked = 0;
            n_bad     = 0;
            clear_block();
        endfunction

        function void clear_block();
            prev_smp  = '0;
            n_in      = '0;
            n_out     = '0;
            phase_rem = '0;
            src_idx   = '0;
            held[0]   = '0;
            held[1]   = '0;
            held_cnt  = 0;
        endfunction

        function void set_rate(lir_cfg_idx_t idx, logic [RATE_W-1:0] val);
            if (idx == CFG_IN_RATE)
                in_rate = val;
            else
                out_rate = val;
        endfunction

        // positions at or past the newest sample use the newest sample
        function longint pick(longint unsigned j, longint unsigned m, longint p, longint c);
            return (j + 1 >= m) ? c : p;
        endfunction

        // round((s0*(b-rem) + s1*rem) / b), halves up, done on an offset numerator
        function logic [SAMPLE_W-1:0] blend(longint s0, longint s1,
                                            longint unsigned rem, longint unsigned b);
            longint          num;
            longint unsigned u;
            longint unsigned q;
            num = s0 * longint'(b - rem) + s1 * longint'(rem);
            u   = $unsigned(num + 64'sd32768 * longint'(b));
            q   = (2 * u + b) / (2 * b);
            q   = q - 64'd32768;
            return q[SAMPLE_W-1:0];
        endfunction

        function void step_phase(longint unsigned a, longint unsigned b);
            longint unsigned sum;
            longint unsigned nxt;
            sum       = phase_rem + a;
            nxt       = src_idx + sum / b;
            src_idx   = nxt[31:0];
            sum       = sum % b;
            phase_rem = sum[RATE_W-1:0];
        endfunction

        function void pop_held();
            due_q.push_back({held[0], 1'b0});
            held[0] = held[1];
            held_cnt--;
            n_out++;
            burst++;
        endfunction

        // work out what one accepted input sample releases
        function void note_sample(logic [SAMPLE_W-1:0] smp, logic fin);
            longint          c;
            longint unsigned a;
            longint unsigned b;
            longint unsigned m;
            longint unsigned r;
            longint unsigned j;
            c     = longint'($signed(smp));
            a     = in_rate;
            b     = out_rate;
            burst = 0;

            // zero or equal rates: straight through
            if (a == 0 || b == 0 || a == b)
            begin
                due_q.push_back({smp, fin});
                if (fin)
                    clear_block();
                else
                begin
                    prev_smp = smp;
                    n_in++;
                end
                return;
            end

            m = n_in + 64'd1;
            r = (2 * m * b + a) / (2 * a);

            // mid-block: release only outputs proven not to be the last
            if (!fin)
            begin
                forever
                begin
                    while (held_cnt > 0 && burst < BURST_CAP && n_out + 64'd1 < r)
                        pop_held();
                    if (held_cnt < 2 && burst < BURST_CAP && src_idx + 64'd2 <= m)
                    begin
                        j = src_idx;
                        held[held_cnt] = blend(pick(j, m, prev_smp, c),
                                               pick(j + 1, m, prev_smp, c), phase_rem, b);
                        held_cnt++;
                        step_phase(a, b);
                    end
                    else
                        break;
                end
                prev_smp = smp;
                n_in     = m[31:0];
                return;
            end

            // final input: flush the hold, then compute the rest, capped
            if (r < 1)
                r = 1;
            while (held_cnt > 0 && burst < BURST_CAP && n_out < r)
                pop_held();
            while (held_cnt == 0 && burst < BURST_CAP && n_out < r)
            begin
                j = src_idx;
                due_q.push_back({blend(pick(j, m, prev_smp, c),
                                       pick(j + 1, m, prev_smp, c), phase_rem, b), 1'b0});
                step_phase(a, b);
                n_out++;
                burst++;
            end
            if (burst > 0)
                due_q[due_q.size() - 1].fin = 1'b1;
            clear_block();
        endfunction

        function void flag(string what, resampled_t want, logic [SAMPLE_W-1:0] smp, logic fin);
            n_bad++;
            if (n_bad <= MAX_REPORTS)
                $display("%0t: %s: sample exp %h got %h, last exp %b got %b",
                         $time, what, want.smp, smp, want.fin, fin);
        endfunction

        // compare one output request with the oldest owed output
        function void check_result(logic [SAMPLE_W-1:0] smp, logic fin);
            resampled_t want;
            n_checked++;
            if (due_q.size() == 0)
            begin
                flag("unexpected output", '0, smp, fin);
                return;
            end
            want = due_q.pop_front();
            if (want.smp !== smp && want.fin !== fin)
                flag("sample and last differ", want, smp, fin);
            else if (want.smp !== smp)
                flag("sample differs", want, smp, fin);
            else if (want.fin !== fin)
                flag("last differs", want, smp, fin);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    lir_cfg_idx_t        cfg_index     = CFG_IN_RATE;
    logic [RATE_W-1:0]   cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;    // sample_in
    logic                s_axis_tlast  = 1'b0;  // final_in
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;          // sample_out
    logic                m_axis_tlast;          // final_out

    resample_scoreboard sb = new();

    int tx_idle_pct  = 32;
    int rx_idle_pct  = 51;
    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int n_sent       = 0;
    int n_blocks     = 0;
    int n_settings   = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    linear_interp_resampler #(
        .MAX_UPSAMPLE (MAX_UP),
        .SAMPLE_BITS  (SAMPLE_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Output side: check accepted requests, random ready, long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_req_cnt != hold_seen)
            begin
                hold_seen     <= hold_req_cnt;
                hold_left     <= HOLD_OFF_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Input side tasks
    // ------------------------------------------------------------------------
    // one input request, with random gaps ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fin);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(smp, fin);
        n_sent++;
        if (fin)
            n_blocks++;
    endtask

    // stop sending and wait for every owed output
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
    endtask

    // rate change while idle; an input may still be at work with nothing owed
    task automatic set_rates(input logic [RATE_W-1:0] ir, input logic [RATE_W-1:0] orr);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IN_RATE;
        cfg_data  <= ir;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_rate(CFG_IN_RATE, ir);
        cfg_index <= CFG_OUT_RATE;
        cfg_data  <= orr;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_rate(CFG_OUT_RATE, orr);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // extremes often, otherwise any value
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7, 0))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // random blocks of 1..10 samples; with close_run the run ends on a block boundary
    task automatic send_random_run(input int n_items, input bit close_run);
        int left_in_block;
        left_in_block = $urandom_range(10, 1);
        for (int i = 0; i < n_items; i++)
        begin
            left_in_block--;
            send_sample(rand_sample(),
                        (left_in_block == 0) || (close_run && i == n_items - 1));
            if (left_in_block == 0)
                left_in_block = $urandom_range(10, 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int ir;
        int orr;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rates are equal: pass-through
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);

        // full 8x upsampling, then a single-sample block
        set_rates(18'd8000, 18'd64000);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b1);

        // a zero rate on either side passes samples through
        set_rates(18'd192000, 18'd0);
        send_sample(16'h1234, 1'b0);
        send_sample(16'hEDCB, 1'b1);
        set_rates(18'd0, 18'd192000);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);

        // ratio far beyond the cap: bursts truncated
        set_rates(18'd1000, 18'd192000);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h4000, 1'b1);

        // extreme downsampling: one output for the whole block
        set_rates(18'd192000, 18'd1);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h7FFE, 1'b0);
        send_sample(16'h0001, 1'b1);

        // rate change inside a block: stale operands, maybe nothing left to send
        set_rates(18'd44100, 18'd48000);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h2AAA, 1'b0);
        set_rates(18'd48000, 18'd8000);
        send_sample(16'hD555, 1'b1);

        // random blocks under changing rates and idling patterns
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph / 3)
                0: begin tx_idle_pct = 32; rx_idle_pct = 51; end
                1: begin tx_idle_pct = 51; rx_idle_pct = 32; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph % 4)
                0:
                begin
                    ir  = $urandom_range(24000, 8000);
                    orr = $urandom_range(8 * ir, ir + 1);
                end
                1:
                begin
                    ir  = $urandom_range(192000, 24000);
                    orr = $urandom_range(ir - 1, ir / 8 + 1);
                end
                2:
                begin
                    ir  = $urandom_range(192000, 1);
                    orr = ir;
                end
                default:
                begin
                    ir  = $urandom_range(192000, 0);
                    orr = $urandom_range(192000, 0);
                end
            endcase
            set_rates(RATE_W'(ir), RATE_W'(orr));

            // receiver holds off long enough for the input to back up
            if (ph == 0)
                hold_req_cnt++;

            if (ph == 4)
            begin
                // sender pauses inside a block until every output is back
                send_random_run(8, 1'b0);
                drain();
                send_random_run(8, 1'b1);
            end
            else
                send_random_run(15, 1'b1);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d samples in %0d blocks over %0d rate settings,", n_sent, n_blocks,
                 n_settings);
        $display("checked %0d output samples, %0d mismatches.", sb.n_checked, sb.n_bad);
        if (sb.n_bad == 0)
            $display("PASS linear_interp_resampler");
        else
            $display("FAIL linear_interp_resampler");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #8_000_000;
        $display("Timed out with %0d outputs still owed", sb.due_q.size());
        $display("FAIL linear_interp_resampler");
        $finish;
    end

endmodule
